// ----- design/ccmp_pkg.sv -----
`timescale 1ns / 1ps
package ccmp_pkg;

    localparam int KEY_W   = 64;
    localparam int NROUNDS = 10;

    localparam logic [7:0] CTR_FLAGS    = 8'h01;
    localparam logic [7:0] CTR_PRIORITY = 8'h00;

    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW  = 1'b1;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // Side data carried alongside each block through the rounds.
    typedef struct packed {
        logic [127:0] cipher;
        logic [4:0]   vbytes;
        logic         last;
    } t_side;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte 0 of the state sits in bits 127:120.
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[127-8*(i+4*c) -: 8] = SBOX[s[127-8*(i+4*((c+i)%4)) -: 8]];
            end
        end
        sub_shift = t;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127-32*c -: 8];
            a1 = s[119-32*c -: 8];
            a2 = s[111-32*c -: 8];
            a3 = s[103-32*c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127-32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[119-32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[111-32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[103-32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        mix_cols = t;
    endfunction

    function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

endpackage

// ----- design/ccmp_key_sched.sv -----
`timescale 1ns / 1ps
// Holds the key as round key 0 and expands ten more in turn after each
// write or reset. The busy flag stays high until the last round key has
// been written, and the top level refuses new beats while it is high.
module ccmp_key_sched (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [0:0]    i_idx,
    input  logic [63:0]   i_data,
    output logic [127:0]  o_rk [11],
    output logic          o_busy
);
    logic [127:0] r_rk [11];
    logic [3:0]   r_step;
    logic         r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rk[0] <= '0;
            r_step  <= 4'd1;
            r_busy  <= 1'b1;
        end else if (i_we) begin
            unique case (i_idx)
                ccmp_pkg::REG_KEY_HIGH: r_rk[0][127:64] <= i_data;
                ccmp_pkg::REG_KEY_LOW:  r_rk[0][63:0]   <= i_data;
                default: ;
            endcase
            r_step <= 4'd1;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_rk[r_step] <= ccmp_pkg::next_key(r_rk[r_step-4'd1], ccmp_pkg::RCON[r_step-4'd1]);
            if (r_step == 4'(ccmp_pkg::NROUNDS)) r_busy <= 1'b0;
            r_step <= r_step + 4'd1;
        end
    end

    assign o_rk   = r_rk;
    assign o_busy = r_busy;
endmodule

// ----- design/ccmp_round.sv -----
`timescale 1ns / 1ps
// One registered AES round with its side data; holds while stalled.
module ccmp_round #(
    parameter bit FINAL = 1'b0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [127:0]     i_state,
    input  ccmp_pkg::t_side  i_side,
    input  logic [127:0]     i_rk,
    output logic             o_valid,
    output logic [127:0]     o_state,
    output ccmp_pkg::t_side  o_side
);
    logic [127:0] w_ss, n_state;
    assign w_ss    = ccmp_pkg::sub_shift(i_state);
    assign n_state = (FINAL ? w_ss : ccmp_pkg::mix_cols(w_ss)) ^ i_rk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (i_en) o_valid <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_state <= n_state;
            o_side  <= i_side;
        end
    end
endmodule

// ----- design/ccmp_ctr_payload_decrypt.sv -----
`timescale 1ns / 1ps
// CCMP counter-mode payload decryption, one 16-byte chunk per beat.
// Slave channel: tdata carries the ciphertext, valid byte count, block index,
// transmitter address and packet number; tlast marks the final chunk.
// Master channel: tdata carries the plaintext and byte count; tlast copies
// the input marker. Bytes at or past the valid count come out as zero.
// The key is written through the plain write port (index 0 upper, 1 lower
// half). After a write, or after reset, the round keys are re-expanded, and
// the slave tready is held low until the last round key is written; the key
// must be written only while no beat is in flight.
// The accepting edge loads the whitened counter block into the first register,
// the ten AES rounds follow with one register each, and the output register
// is loaded last.
// Throughput is one beat per cycle between stalls and key expansions: the
// twelve registers form a single pipeline whose stages all advance together.
// A stalled receiver freezes the whole pipeline; the slave tready goes low
// when the output register holds a beat that is not being taken, so nothing
// is lost or repeated. Reset clears all valid bits and starts the expansion
// of the all-zero key.
module ccmp_ctr_payload_decrypt (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_idx,
    input  logic [63:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cipher_high, cipher_low, valid_bytes, block_index, transmitter_addr,
    // packet_number (low bit up), zero fill to 248 bits
    input  logic [247:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // plain_high, plain_low, out_valid_bytes (low bit up), zero fill to 136
    output logic [135:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    localparam int NR = ccmp_pkg::NROUNDS;

    logic [127:0] w_rk [11];
    logic         w_busy;
    ccmp_key_sched u_key (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(i_cfg_we), .i_idx(i_cfg_idx),
        .i_data(i_cfg_data), .o_rk(w_rk), .o_busy(w_busy)
    );

    // The pipeline advances whenever the output register is free or drains.
    // New beats are refused while the round keys are being expanded.
    logic w_en;
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en && !w_busy;

    logic [127:0] w_ctr;
    assign w_ctr = {ccmp_pkg::CTR_FLAGS, ccmp_pkg::CTR_PRIORITY,
                    s_axis_tdata[196:149], s_axis_tdata[244:197], s_axis_tdata[148:133]};

    logic            r_v  [NR+1];
    logic [127:0]    r_st [NR+1];
    ccmp_pkg::t_side r_sd [NR+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v[0] <= 1'b0;
        else if (w_en) r_v[0] <= s_axis_tvalid && !w_busy;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st[0] <= w_ctr ^ w_rk[0];
            r_sd[0] <= '{cipher: {s_axis_tdata[63:0], s_axis_tdata[127:64]},
                         vbytes: s_axis_tdata[132:128], last: s_axis_tlast};
        end
    end

    for (genvar g = 1; g <= NR; g++) begin : g_rnd
        ccmp_round #(.FINAL(g == NR)) u_rnd (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_valid(r_v[g-1]), .i_state(r_st[g-1]), .i_side(r_sd[g-1]),
            .i_rk(w_rk[g]), .o_valid(r_v[g]), .o_state(r_st[g]), .o_side(r_sd[g])
        );
    end

    // Keep only the leading valid bytes; counts above sixteen keep all.
    logic [127:0] n_plain;
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            n_plain[127-8*i -: 8] = (5'(i) < r_sd[NR].vbytes)
                ? (r_st[NR][127-8*i -: 8] ^ r_sd[NR].cipher[127-8*i -: 8]) : 8'h00;
        end
    end

    logic [127:0] r_plain;
    logic [4:0]   r_vb;
    logic         r_last;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tvalid <= 1'b0;
        else if (w_en) m_axis_tvalid <= r_v[NR];
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_plain <= n_plain;
            r_vb    <= r_sd[NR].vbytes;
            r_last  <= r_sd[NR].last;
        end
    end

    assign m_axis_tdata = {3'b000, r_vb, r_plain[63:0], r_plain[127:64]};
    assign m_axis_tlast = r_last;
endmodule

// ----- design/ccmp_checker.sv -----
`timescale 1ns / 1ps
module ccmp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata,
    input logic         m_axis_tlast
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast)) else $error("output changed under stall");
    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> !s_axis_tready)
        else $error("input taken before the round keys are ready");
    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while stalled");
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
endmodule

bind ccmp_ctr_payload_decrypt ccmp_checker u_chk (.*);

// ----- dv/tb_ccmp_ctr_payload_decrypt.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the CCMP counter-mode payload decryptor.
// Chunks are fed on the slave stream with random gaps, and the master stream
// is back-pressured at random. Every accepted chunk is decrypted here by an
// independent AES-128 CTR model, and the plaintext is queued. Each beat that
// leaves the block is then compared, field by field, with the oldest queued
// plaintext.
module tb_ccmp_ctr_payload_decrypt;

    // The round keys are re-expanded after reset or a key write, and the pipeline
    // is twelve stages deep; SETTLE leaves room for both.
    localparam int SETTLE     = 30;
    localparam int WDOG_LIMIT = 5000;
    localparam int N_RANDOM   = 1000;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
        logic [4:0]  valid_bytes;
        logic [15:0] block_index;
        logic [47:0] ta;
        logic [47:0] pn;
        logic        last;
    } t_chunk;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
        logic [4:0]  valid_bytes;
        logic        last;
    } t_plain;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [0:0]   i_cfg_idx;
    logic [63:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [247:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;
    logic         m_axis_tlast;

    ccmp_ctr_payload_decrypt dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Our own copy of the key and of the eleven round keys.
    logic [63:0]  key_hi_q, key_lo_q;
    logic [127:0] round_keys [11];

    t_plain expected_plain [$];
    int     n_errors;
    int     idle_cycles;
    bit     gaps_on;
    bit     stall_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Expand the current key into the eleven round keys.
    function automatic void expand_round_keys();
        logic [31:0] w0, w1, w2, w3, t;
        logic [7:0]  rc;
        rc = 8'h01;
        round_keys[0] = {key_hi_q, key_lo_q};
        for (int r = 1; r <= 10; r++) begin
            {w0, w1, w2, w3} = round_keys[r-1];
            t  = {ccmp_pkg::SBOX[w3[23:16]] ^ rc, ccmp_pkg::SBOX[w3[15:8]],
                  ccmp_pkg::SBOX[w3[7:0]], ccmp_pkg::SBOX[w3[31:24]]};
            w0 = w0 ^ t;
            w1 = w1 ^ w0;
            w2 = w2 ^ w1;
            w3 = w3 ^ w2;
            round_keys[r] = {w0, w1, w2, w3};
            rc = gf_double(rc);
        end
    endfunction

    // AES-128 encryption of one block; byte 0 lives in bits 127:120.
    function automatic logic [127:0] aes_encrypt_block(input logic [127:0] blk);
        logic [127:0] s, t;
        logic [7:0]   a0, a1, a2, a3, al;
        s = blk ^ round_keys[0];
        for (int r = 1; r <= 10; r++) begin
            // SubBytes and ShiftRows together.
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[127-8*(i+4*c) -: 8] = ccmp_pkg::SBOX[s[127-8*(i+4*((c+i)%4)) -: 8]];
            s = t;
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = s[127-32*c -: 8];
                    a1 = s[119-32*c -: 8];
                    a2 = s[111-32*c -: 8];
                    a3 = s[103-32*c -: 8];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    s[127-32*c -: 8] = a0 ^ al ^ gf_double(a0 ^ a1);
                    s[119-32*c -: 8] = a1 ^ al ^ gf_double(a1 ^ a2);
                    s[111-32*c -: 8] = a2 ^ al ^ gf_double(a2 ^ a3);
                    s[103-32*c -: 8] = a3 ^ al ^ gf_double(a3 ^ a0);
                end
            end
            s = s ^ round_keys[r];
        end
        return s;
    endfunction

    // Counter block, keystream, XOR and masking of the bytes past the count.
    function automatic t_plain decrypt_chunk(input t_chunk c);
        t_plain       p;
        logic [127:0] ks, data;
        int           keep;
        ks   = aes_encrypt_block({ccmp_pkg::CTR_FLAGS, ccmp_pkg::CTR_PRIORITY,
                                  c.ta, c.pn, c.block_index});
        data = {c.cipher_high, c.cipher_low} ^ ks;
        // A count above sixteen keeps every byte; zero keeps none.
        keep = (c.valid_bytes > 16) ? 16 : c.valid_bytes;
        for (int n = keep; n < 16; n++)
            data[127-8*n -: 8] = 8'h00;
        p.plain_high  = data[127:64];
        p.plain_low   = data[63:0];
        p.valid_bytes = c.valid_bytes;
        p.last        = c.last;
        return p;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
        n_errors++;
    endtask

    // Send one chunk and queue its plaintext once it has been accepted.
    // tvalid stays high afterwards so that chunks can follow back to back;
    // whoever waits for the pipeline to drain drops it first.
    task automatic send_chunk(input t_chunk c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'd0, c.pn, c.ta, c.block_index, c.valid_bytes,
                          c.cipher_low, c.cipher_high};
        s_axis_tlast  <= c.last;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        expected_plain = {expected_plain, decrypt_chunk(c)};
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_plain.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Key writes only happen with the pipeline empty.
    task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ccmp_pkg::REG_KEY_HIGH;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_idx  <= ccmp_pkg::REG_KEY_LOW;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        key_hi_q = hi;
        key_lo_q = lo;
        expand_round_keys();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_chunk random_chunk();
        t_chunk c;
        c.cipher_high = {$urandom, $urandom};
        c.cipher_low  = {$urandom, $urandom};
        // Mostly legal counts, now and then the out-of-range ones.
        c.valid_bytes = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                    : 5'($urandom_range(1, 16));
        c.block_index = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(1, 8));
        c.ta          = {16'($urandom), $urandom};
        c.pn          = {16'($urandom), $urandom};
        c.last        = 1'b0;
        return c;
    endfunction

    // Field extremes and the odd byte counts under the reset key, then chunks under two written keys.
    task automatic test_directed();
        t_chunk c;
        logic [4:0] counts [6] = '{5'd0, 5'd1, 5'd15, 5'd16, 5'd17, 5'd31};
        gaps_on = 1'b0;
        c = '0;
        send_chunk(c);
        c = '1;
        send_chunk(c);
        foreach (counts[k]) begin
            c = random_chunk();
            c.valid_bytes = counts[k];
            c.last        = k[0];
            send_chunk(c);
        end
        c = random_chunk();
        c.block_index = 16'd0;
        send_chunk(c);
        c.block_index = 16'hffff;
        send_chunk(c);
        write_key('1, '1);
        c = '1;
        send_chunk(c);
        c = '0;
        c.valid_bytes = 5'd16;
        c.block_index = 16'd1;
        send_chunk(c);
        write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
        repeat (4) send_chunk(random_chunk());
    endtask

    // Payloads of random length under a few keys, with idle stretches.
    task automatic test_random_payloads();
        t_chunk c;
        int     sent, len;
        logic [47:0] ta, pn;
        sent = 0;
        while (sent < N_RANDOM) begin
            if (sent % 250 == 0)
                write_key({$urandom, $urandom}, {$urandom, $urandom});
            gaps_on  = ($urandom_range(0, 4) != 0);
            stall_on = ($urandom_range(0, 4) != 0);
            len = $urandom_range(1, 6);
            ta  = {16'($urandom), $urandom};
            pn  = {16'($urandom), $urandom};
            for (int b = 1; b <= len; b++) begin
                c = random_chunk();
                // Most chunks belong to a well-formed payload.
                if ($urandom_range(0, 7) != 0) begin
                    c.ta          = ta;
                    c.pn          = pn;
                    c.block_index = 16'(b);
                    c.valid_bytes = (b == len) ? c.valid_bytes : 5'd16;
                    c.last        = (b == len);
                end else begin
                    c.last = 1'($urandom_range(0, 1));
                end
                send_chunk(c);
                sent++;
            end
        end
        gaps_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    // The sender holds off until the pipeline has fully drained.
    task automatic test_drain_pause();
        repeat (8) send_chunk(random_chunk());
        wait_drained();
        repeat (8) send_chunk(random_chunk());
    endtask

    // Receiver: random stalls, with stretches where it always accepts.
    always @(posedge i_clk) begin
        if (!stall_on) begin
            m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 99) < 8) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 19) != 0);
        end
    end

    // Compare each beat leaving the block with the oldest queued plaintext.
    always @(posedge i_clk) begin
        t_plain want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_plain.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata[63:0], '0);
            end else begin
                want = expected_plain.pop_front();
                if (m_axis_tdata[63:0] !== want.plain_high)
                    report_mismatch("plain_high", m_axis_tdata[63:0], want.plain_high);
                if (m_axis_tdata[127:64] !== want.plain_low)
                    report_mismatch("plain_low", m_axis_tdata[127:64], want.plain_low);
                if (m_axis_tdata[132:128] !== want.valid_bytes)
                    report_mismatch("valid_bytes", 64'(m_axis_tdata[132:128]),
                                    64'(want.valid_bytes));
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
            end
        end
    end

    // Watchdog: a run with no beat moving on either side for too long is hung.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        n_errors      = 0;
        idle_cycles   = 0;
        gaps_on       = 1'b1;
        stall_on      = 1'b1;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= ccmp_pkg::REG_KEY_HIGH;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        key_hi_q = '0;
        key_lo_q = '0;
        expand_round_keys();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE) @(posedge i_clk);

        test_directed();
        test_drain_pause();
        test_random_payloads();
        write_key('0, '0);
        test_drain_pause();

        wait_drained();
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
